FILE: src/iam_pkg.sv
// Shared types, constants and codes for the indexed array list unit.
package iam_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 5;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int ACT_W    = 3;
   localparam int ST_W     = 2;

   localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DROP   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd4;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   typedef struct packed {
      logic [ACT_W-1:0]         action;
      logic [POS_W-1:0]         position;
      logic signed [WORD_W-1:0] word_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] word_out;
      logic [ST_W-1:0]          status;
      logic [CNT_W-1:0]         count_now;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: src/iam_cell.sv
// One storage cell of the list: holds an entry, loads a word or takes its upper neighbour's.
module iam_cell (
   input  logic                              clock,
   input  iam_pkg::cell_ctl_type             ctl,
   input  logic signed [iam_pkg::WORD_W-1:0] wr_word,
   input  logic signed [iam_pkg::WORD_W-1:0] upper_word,
   output logic signed [iam_pkg::WORD_W-1:0] word
);
   import iam_pkg::*;

   logic signed [WORD_W-1:0] word_ff;
   logic signed [WORD_W-1:0] word_in;

   always_comb begin
      priority if (ctl.shift) begin
         word_in = upper_word;
      end else if (ctl.load) begin
         word_in = wr_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule

FILE: src/indexed_array_list_unit.sv
// Top level of the indexed array list unit: sequencer, row of entry cells, result register.
//
// Usage
//  - Command channel: drive req_data and raise start; a beat is taken at a rising
//    edge where start is high and busy is low. busy stays low, so a beat may be
//    offered in every cycle.
//  - Each beat yields one result beat: rsp_valid is high for exactly one cycle,
//    in the cycle after the command beat, with rsp_data holding the word read, the
//    status and the entry count after the action.
//  - Throughput: one command per cycle. Every action, removal included, is done
//    in the cycle it is taken: all cells at or above the index copy their upper
//    neighbour in parallel, so the count and entries are current for the next beat.
//  - Results are held in the result register.
//  - The receiver has no back-pressure; it must take each result beat as shown.
//  - Reset (synchronous, active high) clears the count and the result strobe.
//    Cell contents are left as they are; no action reads a cell at or above the
//    count, so stale data is never seen.
//  - Failed actions (full, empty, index out of range) are flagged in status and
//    leave the state untouched. Unknown action codes report ok and change nothing.
module indexed_array_list_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  iam_pkg::req_type req_data,
   output logic             rsp_valid,
   output iam_pkg::rsp_type rsp_data
);
   import iam_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             accept;

   // sequencer decisions for this beat
   logic             load_en;
   logic [IDX_W-1:0] load_idx;
   logic             shift_en;
   logic [IDX_W-1:0] shift_idx;
   logic [ST_W-1:0]  idx_st;

   cell_ctl_type             cell_ctl [CAPACITY];
   logic signed [WORD_W-1:0] cell_word [CAPACITY];

   // whole-cycle actions: never stalls
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // index check shared by read, write and remove
   always_comb begin
      priority if (count_ff == '0) begin
         idx_st = ST_EMPTY;
      end else if (req_data.position >= count_ff) begin
         idx_st = ST_RANGE;
      end else begin
         idx_st = ST_OK;
      end
   end

   always_comb begin
      count_in         = count_ff;
      load_en          = 1'b0;
      load_idx         = req_data.position[IDX_W-1:0];
      shift_en         = 1'b0;
      shift_idx        = req_data.position[IDX_W-1:0];
      rsp_in.word_out  = '0;
      rsp_in.status    = ST_OK;
      unique case (req_data.action)
         ACT_APPEND: begin
            if (count_ff >= CNT_FULL) begin
               rsp_in.status = ST_FULL;
            end else begin
               load_en  = accept;
               load_idx = count_ff[IDX_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_DROP: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ACT_READ: begin
            rsp_in.status   = idx_st;
            rsp_in.word_out = (idx_st == ST_OK) ? cell_word[req_data.position[IDX_W-1:0]]
                                                : '1;
         end
         ACT_WRITE: begin
            rsp_in.status = idx_st;
            load_en       = accept && (idx_st == ST_OK);
         end
         ACT_REMOVE: begin
            rsp_in.status = idx_st;
            if (idx_st == ST_OK) begin
               shift_en = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_in.count_now = count_in;
   end

   // row of cells; each one takes its upper neighbour on a removal at or below it
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [WORD_W-1:0] upper;

      if (i == CAPACITY - 1) begin : g_top
         assign upper = cell_word[i];
      end else begin : g_mid
         assign upper = cell_word[i+1];
      end

      assign cell_ctl[i].load  = load_en && (load_idx == IDX_W'(i));
      assign cell_ctl[i].shift = shift_en && (IDX_W'(i) >= shift_idx);

      iam_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .wr_word    (req_data.word_in),
         .upper_word (upper),
         .word       (cell_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count above capacity");

   // each command beat gives one result beat in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("result beat missing");

   // reported count matches the held count
   a_count_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.count_now == count_ff))
      else $error("reported count differs from held count");

   // full is only reported with a full list
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_FULL)) |-> (rsp_data.count_now == CNT_FULL))
      else $error("full status on a list that is not full");
endmodule
